// ----- sv/ismc_pkg.sv -----
// Shared types and constants for the interval scheduling count unit.
// No dependencies.
`default_nettype none
package ismc_pkg;
    localparam int MAX_INTERVALS = 128;
    localparam int TIME_W        = 16;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int COUNT_W       = 8;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              last_interval;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] chosen_count;
        logic               overflow;
    } out_item_t;

    // queue entry from front to back
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              wr;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic [CNT_W-1:0]  n;
        logic              ovf;
    } qent_t;

    // ordering key: end, then start, then store index; compares as unsigned
    typedef struct packed {
        logic [TIME_W-1:0] e;
        logic [TIME_W-1:0] s;
        logic [IDX_W-1:0]  i;
    } key_t;

    typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_OUT} back_st_t;
endpackage
`default_nettype wire

// ----- sv/ismc_front.sv -----
// Front end: accepts intervals, assigns store slots, flags overflow.
// Depends on ismc_pkg.
`default_nettype none
module ismc_front
    import ismc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output qent_t         q_data
);
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             room;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign room    = (count_reg < CNT_W'(MAX_INTERVALS));

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (room) begin
            count_next = count_reg + 1'b1;
        end else begin
            ovf_next = 1'b1;
        end
        q_data.start_time = s_data.start_time;
        q_data.end_time   = s_data.end_time;
        q_data.wr         = room;
        q_data.idx        = count_reg[IDX_W-1:0];
        q_data.last       = s_data.last_interval;
        q_data.n          = count_next;
        q_data.ovf        = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (q_push) begin
            if (s_data.last_interval) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/ismc_queue.sv -----
// Short queue between front and back ends.
// Depends on ismc_pkg.
`default_nettype none
module ismc_queue
    import ismc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire qent_t wdata,
    output logic       full,
    input  wire logic  pop,
    output logic       not_empty,
    output qent_t      rdata
);
    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   fill_reg;

    assign full      = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (fill_reg != '0);
    assign rdata     = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            if (push && !pop)      fill_reg <= fill_reg + 1'b1;
            else if (pop && !push) fill_reg <= fill_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- sv/ismc_back.sv -----
// Back end: interval store, repeated min-key selection scan, result register.
// Depends on ismc_pkg.
`default_nettype none
module ismc_back
    import ismc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_valid,
    input  wire qent_t q_data,
    output logic       q_pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_item_t  m_data
);
    logic [2*TIME_W-1:0] mem [MAX_INTERVALS];
    logic [2*TIME_W-1:0] rdata_reg;

    back_st_t           st_reg, st_next;
    logic [CNT_W-1:0]   n_reg, n_next, addr_reg, addr_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   ridx_reg;
    logic               rvld_reg, rvld_next;
    logic [TIME_W-1:0]  cur_reg, cur_next;
    key_t               lastk_reg, lastk_next, best_reg, best_next;
    logic               first_reg, first_next, found_reg, found_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               issue;
    key_t               k;
    logic               elig;

    always_comb begin
        k.e = rdata_reg[TIME_W-1:0];
        k.s = rdata_reg[2*TIME_W-1:TIME_W];
        k.i = ridx_reg;
        elig = (k.s >= cur_reg) && (first_reg || (k > lastk_reg));
    end

    always_comb begin
        st_next    = st_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        addr_next  = addr_reg;
        rvld_next  = 1'b0;
        cur_next   = cur_reg;
        lastk_next = lastk_reg;
        best_next  = best_reg;
        first_next = first_reg;
        found_next = found_reg;
        cnt_next   = cnt_reg;
        issue      = 1'b0;
        q_pop      = 1'b0;
        m_valid    = 1'b0;
        unique case (st_reg)
            ST_LOAD: begin
                q_pop = q_valid;
                if (q_valid && q_data.last) begin
                    n_next     = q_data.n;
                    ovf_next   = q_data.ovf;
                    addr_next  = '0;
                    cur_next   = '0;
                    first_next = 1'b1;
                    found_next = 1'b0;
                    cnt_next   = '0;
                    st_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (addr_reg < n_reg) begin
                    issue     = 1'b1;
                    rvld_next = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                if (rvld_reg && elig && (!found_reg || (k < best_reg))) begin
                    best_next  = k;
                    found_next = 1'b1;
                end
                if (addr_reg == n_reg && !rvld_reg) begin
                    if (found_reg) begin
                        if (cnt_reg != '1) cnt_next = cnt_reg + 1'b1;
                        cur_next   = best_reg.e;
                        lastk_next = best_reg;
                        first_next = 1'b0;
                        found_next = 1'b0;
                        addr_next  = '0;
                    end else begin
                        st_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) st_next = ST_LOAD;
            end
            default: st_next = ST_LOAD;
        endcase
    end

    assign m_data.chosen_count = cnt_reg;
    assign m_data.overflow     = ovf_reg;

    always_ff @(posedge aclk) begin
        if (q_pop && q_data.wr) mem[q_data.idx] <= {q_data.start_time, q_data.end_time};
        if (issue) begin
            rdata_reg <= mem[addr_reg[IDX_W-1:0]];
            ridx_reg  <= addr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_LOAD;
            rvld_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            rvld_reg <= rvld_next;
        end
        n_reg     <= n_next;
        ovf_reg   <= ovf_next;
        addr_reg  <= addr_next;
        cur_reg   <= cur_next;
        lastk_reg <= lastk_next;
        best_reg  <= best_next;
        first_reg <= first_next;
        found_reg <= found_next;
        cnt_reg   <= cnt_next;
    end
endmodule
`default_nettype wire

// ----- sv/interval_scheduling_max_count_unit.sv -----
// Top level of the interval scheduling count unit: front end, queue, back end.
// Depends on ismc_pkg, ismc_front, ismc_queue, ismc_back.
//
//  channel | dir | ports                     | item
//  s_      | in  | s_valid s_ready s_data    | one interval, last marks end of set
//  m_      | out | m_valid m_ready m_data    | chosen count and overflow, one per set
//
// Intervals are taken one per cycle while the 4-entry queue has room.
// On the last item the back end runs selection passes over the store, one
// entry read per cycle, one pass per chosen interval plus a final pass that
// finds none; the store has a single read port. Later items queue meanwhile.
// Reset is synchronous, active low, and clears counts and state only.
// The result waits in its register until m_ready; the back end holds.
`default_nettype none
module interval_scheduling_max_count_unit
    import ismc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);
    logic  q_full, q_push, q_pop, q_ne;
    qent_t q_wdata, q_rdata;

    // front: slot allocation and overflow
    ismc_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_full, .q_push, .q_data(q_wdata)
    );

    // queue lets the front keep accepting while the back scans
    ismc_queue u_queue (
        .aclk, .aresetn, .push(q_push), .wdata(q_wdata), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .rdata(q_rdata)
    );

    // back: store, greedy selection, result
    ismc_back u_back (
        .aclk, .aresetn, .q_valid(q_ne), .q_data(q_rdata), .q_pop,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

// ----- sv/ismc_checker.sv -----
// Port-level checks for the interval scheduling count unit, with bind.
// Depends on ismc_pkg.
`default_nettype none
module ismc_port_checks
    import ismc_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);
    // result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one result per set: no second result straight after a take
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("result repeated");

    // a set always has at least one interval, so one is always chosen
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.chosen_count != '0)
        else $error("zero count reported");
endmodule

bind interval_scheduling_max_count_unit ismc_port_checks u_ismc_port_checks (
    .aclk, .aresetn, .m_valid, .m_ready, .m_data
);
`default_nettype wire

// ----- test/ismc_checker.sv -----
// Checker for the interval scheduling count unit: watches both channels,
// predicts the chosen count and overflow flag per set, and compares.
// Depends on ismc_pkg.
module ismc_checker
    import ismc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data,
    output int             fail_count,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TIME_W-1:0] set_start [MAX_INTERVALS];
    logic [TIME_W-1:0] set_end   [MAX_INTERVALS];
    int                set_len;
    logic              set_dropped;
    out_item_t         count_q[$];

    // greedy selection over the intervals collected so far
    function automatic out_item_t select_count();
        logic [TIME_W-1:0] s, e, run_end;
        int                j, taken;
        out_item_t         r;
        begin
            for (int i = 1; i < set_len; i++) begin
                s = set_start[i];
                e = set_end[i];
                j = i;
                while (j > 0 && (e < set_end[j-1] ||
                                 (e == set_end[j-1] && s < set_start[j-1]))) begin
                    set_start[j] = set_start[j-1];
                    set_end[j]   = set_end[j-1];
                    j--;
                end
                set_start[j] = s;
                set_end[j]   = e;
            end
            run_end = '0;
            taken   = 0;
            for (int i = 0; i < set_len; i++) begin
                if (run_end <= set_start[i]) begin
                    if (taken < 255) taken++;
                    run_end = set_end[i];
                end
            end
            r.chosen_count = taken[COUNT_W-1:0];
            r.overflow     = set_dropped;
            return r;
        end
    endfunction

    assign pending = count_q.size();

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            set_len     = 0;
            set_dropped = 1'b0;
            fail_count  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (set_len < MAX_INTERVALS) begin
                    set_start[set_len] = s_data.start_time;
                    set_end[set_len]   = s_data.end_time;
                    set_len            = set_len + 1;
                end else begin
                    set_dropped = 1'b1;
                end
                if (s_data.last_interval) begin
                    count_q.push_back(select_count());
                    set_len     = 0;
                    set_dropped = 1'b0;
                end
            end
            if (m_valid && m_ready) begin
                if (count_q.size() == 0) begin
                    $display("%0t: unexpected result count=%0d ovf=%0b", $time,
                             m_data.chosen_count, m_data.overflow);
                    fail_count <= fail_count + 1;
                end else begin
                    want = count_q.pop_front();
                    if (want !== m_data) begin
                        $display("%0t: expected count=%0d ovf=%0b, got count=%0d ovf=%0b",
                                 $time, want.chosen_count, want.overflow,
                                 m_data.chosen_count, m_data.overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- test/testbench.sv -----
// Stimulus and verdict for the interval scheduling count unit.
// Depends on ismc_pkg, interval_scheduling_max_count_unit and ismc_checker.
module testbench;
    import ismc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    int        fail_count;
    int        pending;
    int        cycle_cnt;
    logic      stall_mode;

    interval_scheduling_max_count_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    ismc_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Timeout. A full set of 128 has the longest scan; several such sets plus
    // ~150 small sets leave plenty under this ceiling.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 3000000) begin
            $display("interval_scheduling_max_count_unit: mismatch");
            $finish;
        end
    end

    // Receiver back-pressure: alternates between a free-running and a
    // choppy phase, so results are taken both at once and after stalls.
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        m_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // Drive one interval; bursts and gaps between them come from send_set.
    task automatic send_item(input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] en,
                             input logic lst);
        begin
            s_valid <= 1'b1;
            s_data  <= '{start_time: st, end_time: en, last_interval: lst};
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
        end
    endtask

    // Random set: times drawn from a narrow window so overlaps and ties are
    // common; the odd wide time hits the top bits.
    task automatic send_set(input int len, input int span);
        int burst;
        logic [TIME_W-1:0] st, en;
        begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 15) == 0) begin
                    st = TIME_W'($urandom);
                    en = TIME_W'($urandom);
                end else begin
                    st = TIME_W'($urandom_range(0, span));
                    en = st + TIME_W'($urandom_range(0, span / 4 + 1));
                    if ($urandom_range(0, 19) == 0) en = TIME_W'($urandom_range(0, span));
                end
                send_item(st, en, i == len - 1);
                if (--burst == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(negedge aclk);
                    burst = $urandom_range(1, 8);
                end
            end
            s_valid <= 1'b0;
        end
    endtask

    initial begin
        int sent;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        stall_mode = 1'b0;
        cycle_cnt  = 0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: single interval, extremes, ties, zero length,
        // start after end, back-to-back touching intervals.
        send_item(16'h0000, 16'h0000, 1'b1);
        send_item(16'hFFFF, 16'hFFFF, 1'b1);
        send_item(16'hFFFF, 16'h0000, 1'b0);
        send_item(16'h0000, 16'hFFFF, 1'b1);
        send_item(16'd5, 16'd5, 1'b0);
        send_item(16'd3, 16'd5, 1'b0);
        send_item(16'd5, 16'd5, 1'b0);
        send_item(16'd5, 16'd9, 1'b0);
        send_item(16'd9, 16'd9, 1'b1);
        send_item(16'd10, 16'd2, 1'b0);
        send_item(16'd1, 16'd4, 1'b0);
        send_item(16'd4, 16'd8, 1'b0);
        send_item(16'd8, 16'd12, 1'b1);
        send_item(16'hAAAA, 16'h5555, 1'b0);
        send_item(16'h5555, 16'hAAAA, 1'b1);
        s_valid <= 1'b0;

        // Store full: exactly full, one over with the last item dropped, then seven over.
        send_set(MAX_INTERVALS, 4000);
        send_set(MAX_INTERVALS + 1, 65535);
        send_set(MAX_INTERVALS + 7, 300);

        // Random sets, mostly small.
        sent = 0;
        while (sent < 1200) begin
            int len;
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 140)
                                               : $urandom_range(1, 12);
            send_set(len, (len < 4) ? 20 : $urandom_range(10, 65535));
            sent += len;
        end

        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0)
            $display("interval_scheduling_max_count_unit: match");
        else
            $display("interval_scheduling_max_count_unit: mismatch");
        $finish;
    end
endmodule

// ----- files.f -----
sv/ismc_pkg.sv
sv/ismc_front.sv
sv/ismc_queue.sv
sv/ismc_back.sv
sv/interval_scheduling_max_count_unit.sv
sv/ismc_checker.sv
test/ismc_checker.sv
test/testbench.sv
